@@ rtl/jackknife_count_accumulator_top_defines.svh @@
// ----------------------------------------------------------------------------
// Jackknife count accumulator assertion macros
// Shared property shapes for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef JACKKNIFE_COUNT_ACCUMULATOR_TOP_DEFINES_SVH
`define JACKKNIFE_COUNT_ACCUMULATOR_TOP_DEFINES_SVH

// Next-cycle implication, quiet while reset is asserted.
`define JKCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define JKCA_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

// Same-cycle implication that also holds across reset.
`define JKCA_ASSERT_NOW_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/jkca_pkg.sv @@
// ----------------------------------------------------------------------------
// Jackknife count accumulator package
// Sizes, register indexes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package jkca_pkg;

    localparam int MAX_REGIONS = 16;
    localparam int MAX_TUPLE   = 4;
    localparam int MATCHERS    = 8;

    localparam int TBL_DEPTH = MAX_REGIONS * MAX_TUPLE * MATCHERS;
    localparam int ADDR_W    = $clog2(TBL_DEPTH);
    localparam int REG_W     = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int REG_CNT_W = $clog2(MAX_REGIONS + 1);
    localparam int TUP_W     = $clog2(MAX_TUPLE + 1);
    localparam int MAT_W     = (MATCHERS > 1) ? $clog2(MATCHERS) : 1;

    localparam int CNT_W = 63;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_REGIONS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TUPLE_SIZE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EFFICIENT_MODE = 2'd2;

    localparam logic OP_ACCUMULATE = 1'b0;
    localparam logic OP_READ       = 1'b1;

    typedef struct packed {
        logic item_load;   // capture the accepted beat
        logic clear;       // write one zero of the clearing pass
        logic walk_start;  // rewind the region walk
        logic walk;        // read the next region of the walk
        logic rand_acc;    // add into the all-random row
        logic rd_issue;    // start a table read for a read item
        logic out_load;    // load the output register
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic is_read;
        logic is_rand;
        logic is_drop;
        logic walk_last;
        logic out_free;
    } t_stat;

endpackage

@@ rtl/jackknife_count_accumulator_top.sv @@
// ----------------------------------------------------------------------------
// Jackknife count accumulator
// Keeps resampled tuple counts per region, random-point count and matcher,
// plus an all-random row per matcher, and answers single-counter reads.
//
// After reset the block sweeps its 512-entry count table to zero, one entry
// a cycle, and holds o_in_stall high throughout the sweep; configuration
// writes are taken throughout. An input beat is taken only while the block
// is idle. An accumulate into the region table walks the N regions in use,
// as the table's one read port and one write port handle the regions one
// per cycle as a pipelined read-modify-write. An accumulate into the
// all-random row, or one dropped for an out-of-range matcher or random-point
// count, needs no walk. A read waits while a previous result is held in the
// output register. Counters are 63 bits wide and saturate.
// ----------------------------------------------------------------------------
module jackknife_count_accumulator_top
    import jkca_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_op,
    input  logic [31:0]           i_count,
    input  logic [2:0]            i_rand_points,
    input  logic [2:0]            i_matcher_index,
    input  logic [2:0]            i_excl_count,
    input  logic [3:0]            i_excl_region_0,
    input  logic [3:0]            i_excl_region_1,
    input  logic [3:0]            i_excl_region_2,
    input  logic [3:0]            i_excl_region_3,
    input  logic [3:0]            i_read_region,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [CNT_W-1:0]      o_read_value
);

    t_cmd  cmd;
    t_stat stat;

    // Controller: owns the sequence, never touches payload
    jkca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Datapath: registers, count table, output register
    jkca_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_op            (i_op),
        .i_count         (i_count),
        .i_rand_points   (i_rand_points),
        .i_matcher_index (i_matcher_index),
        .i_excl_count    (i_excl_count),
        .i_excl_region_0 (i_excl_region_0),
        .i_excl_region_1 (i_excl_region_1),
        .i_excl_region_2 (i_excl_region_2),
        .i_excl_region_3 (i_excl_region_3),
        .i_read_region   (i_read_region),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_read_value    (o_read_value)
    );

endmodule

@@ rtl/jkca_ctrl.sv @@
// ----------------------------------------------------------------------------
// Jackknife count accumulator controller
// Sequences the clearing pass, item dispatch, region walk and reads.
// ----------------------------------------------------------------------------
module jkca_ctrl
    import jkca_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_in_stall
);

    typedef enum logic [6:0] {
        S_CLEAR    = 7'b0000001,
        S_IDLE     = 7'b0000010,
        S_DISPATCH = 7'b0000100,
        S_WALK     = 7'b0001000,
        S_DRAIN    = 7'b0010000,
        S_RD_WAIT  = 7'b0100000,
        S_SPARE    = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.item_load = 1'b1;
                    n_state         = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                priority if (i_stat.is_read) begin
                    o_cmd.rd_issue = 1'b1;
                    n_state        = S_RD_WAIT;
                end else if (i_stat.is_drop) begin
                    n_state = S_IDLE;
                end else if (i_stat.is_rand) begin
                    o_cmd.rand_acc = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.walk_start = 1'b1;
                    n_state          = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_IDLE;
            end
            S_RD_WAIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_SPARE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

@@ rtl/jkca_dpath.sv @@
// ----------------------------------------------------------------------------
// Jackknife count accumulator datapath
// Configuration, item registers, count table, all-random row and output.
// ----------------------------------------------------------------------------
module jkca_dpath
    import jkca_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_op,
    input  logic [31:0]           i_count,
    input  logic [2:0]            i_rand_points,
    input  logic [2:0]            i_matcher_index,
    input  logic [2:0]            i_excl_count,
    input  logic [3:0]            i_excl_region_0,
    input  logic [3:0]            i_excl_region_1,
    input  logic [3:0]            i_excl_region_2,
    input  logic [3:0]            i_excl_region_3,
    input  logic [3:0]            i_read_region,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [CNT_W-1:0]      o_read_value
);

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [31:0] b);
        logic [CNT_W:0] sum;
        sum = {1'b0, a} + {{(CNT_W - 31){1'b0}}, b};
        return sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input int region, input int nrand,
                                                    input int matcher);
        return ADDR_W'((region * MAX_TUPLE + nrand) * MATCHERS + matcher);
    endfunction

    // Configuration
    logic [4:0] r_num_regions;
    logic [2:0] r_tuple_size;
    logic       r_efficient;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_regions <= 5'd1;
            r_tuple_size  <= 3'd2;
            r_efficient   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NUM_REGIONS:    r_num_regions <= i_cfg_data[4:0];
                CFG_TUPLE_SIZE:     r_tuple_size  <= i_cfg_data[2:0];
                CFG_EFFICIENT_MODE: r_efficient   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [REG_CNT_W-1:0] eff_regions;
    logic [TUP_W-1:0]     eff_tuple;

    always_comb begin
        if (r_num_regions == 5'd0) begin
            eff_regions = REG_CNT_W'(1);
        end else if (int'(r_num_regions) > MAX_REGIONS) begin
            eff_regions = REG_CNT_W'(MAX_REGIONS);
        end else begin
            eff_regions = REG_CNT_W'(r_num_regions);
        end
        if (r_tuple_size == 3'd0) begin
            eff_tuple = TUP_W'(1);
        end else if (int'(r_tuple_size) > MAX_TUPLE) begin
            eff_tuple = TUP_W'(MAX_TUPLE);
        end else begin
            eff_tuple = TUP_W'(r_tuple_size);
        end
    end

    // Item capture
    logic        r_op;
    logic [31:0] r_count;
    logic [2:0]  r_nrand;
    logic [2:0]  r_matcher;
    logic [2:0]  r_nexcl;
    logic [3:0]  r_excl [4];
    logic [3:0]  r_rread;

    always_ff @(posedge i_clk) begin
        if (i_cmd.item_load) begin
            r_op      <= i_op;
            r_count   <= i_count;
            r_nrand   <= i_rand_points;
            r_matcher <= i_matcher_index;
            r_nexcl   <= (i_excl_count > 3'd4) ? 3'd4 : i_excl_count;
            r_excl[0] <= i_excl_region_0;
            r_excl[1] <= i_excl_region_1;
            r_excl[2] <= i_excl_region_2;
            r_excl[3] <= i_excl_region_3;
            r_rread   <= i_read_region;
        end
    end

    logic m_ok;
    logic rand_row;
    logic tbl_ok;
    logic [MAT_W-1:0] mat_idx;

    assign m_ok     = int'(r_matcher) < MATCHERS;
    assign rand_row = int'(r_nrand) == int'(eff_tuple);
    assign tbl_ok   = m_ok && (int'(r_nrand) < int'(eff_tuple))
                      && (int'(r_rread) < int'(eff_regions));
    assign mat_idx  = MAT_W'(r_matcher);

    // Clearing pass and region walk counters
    logic [ADDR_W-1:0] r_clr_addr;
    logic [REG_W-1:0]  r_walk_idx;
    logic              r_wr_vld;
    logic [REG_W-1:0]  r_wr_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_walk_idx <= '0;
            r_wr_vld   <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (i_cmd.walk_start) begin
                r_walk_idx <= '0;
            end else if (i_cmd.walk) begin
                r_walk_idx <= r_walk_idx + REG_W'(1);
            end
            r_wr_vld <= i_cmd.walk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_idx <= r_walk_idx;
    end

    // Decide whether the region now in the write stage takes the count
    logic wr_hit;
    logic wr_en;

    always_comb begin
        wr_hit = 1'b0;
        for (int j = 0; j < 4; j++) begin
            if ((j < int'(r_nexcl)) && (int'(r_excl[j]) == int'(r_wr_idx))) begin
                wr_hit = 1'b1;
            end
        end
        if (eff_regions == REG_CNT_W'(1)) begin
            wr_en = r_wr_vld;
        end else if (r_efficient) begin
            wr_en = r_wr_vld && !wr_hit;
        end else begin
            wr_en = r_wr_vld && (r_nexcl != 3'd0) && (int'(r_excl[0]) == int'(r_wr_idx));
        end
    end

    // Count table: read for the walk or a read item, write for clear or walk
    logic [CNT_W-1:0]  mem [TBL_DEPTH];
    logic [CNT_W-1:0]  r_mem_q;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [CNT_W-1:0]  mem_wd;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_ra;

    always_comb begin
        mem_we = i_cmd.clear || wr_en;
        if (i_cmd.clear) begin
            mem_wa = r_clr_addr;
            mem_wd = '0;
        end else begin
            mem_wa = cell_addr(int'(r_wr_idx), int'(r_nrand), int'(r_matcher));
            mem_wd = sat_add(r_mem_q, r_count);
        end
        mem_re = i_cmd.walk || (i_cmd.rd_issue && tbl_ok);
        if (i_cmd.walk) begin
            mem_ra = cell_addr(int'(r_walk_idx), int'(r_nrand), int'(r_matcher));
        end else begin
            mem_ra = cell_addr(int'(r_rread), int'(r_nrand), int'(r_matcher));
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_mem_q <= mem[mem_ra];
        end
    end

    // All-random row
    logic [CNT_W-1:0] r_rand_cnt [MATCHERS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < MATCHERS; m++) begin
                r_rand_cnt[m] <= '0;
            end
        end else if (i_cmd.rand_acc) begin
            r_rand_cnt[mat_idx] <= sat_add(r_rand_cnt[mat_idx], r_count);
        end
    end

    // Output register
    logic             r_out_vld;
    logic [CNT_W-1:0] r_out_val;
    logic [CNT_W-1:0] rd_result;

    always_comb begin
        if (!m_ok) begin
            rd_result = '0;
        end else if (rand_row) begin
            rd_result = r_rand_cnt[mat_idx];
        end else if (tbl_ok) begin
            rd_result = r_mem_q;
        end else begin
            rd_result = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_val <= rd_result;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_read_value = r_out_val;

    assign o_stat.clear_last = (r_clr_addr == ADDR_W'(TBL_DEPTH - 1));
    assign o_stat.is_read    = (r_op == OP_READ);
    assign o_stat.is_rand    = rand_row;
    assign o_stat.is_drop    = !m_ok || (int'(r_nrand) > int'(eff_tuple));
    assign o_stat.walk_last  = (int'(r_walk_idx) == int'(eff_regions) - 1);
    assign o_stat.out_free   = !r_out_vld || !i_out_stall;

endmodule

@@ rtl/jkca_checker.sv @@
// ----------------------------------------------------------------------------
// Jackknife count accumulator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "jackknife_count_accumulator_top_defines.svh"

module jkca_checker
    import jkca_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic [CNT_W-1:0] o_read_value
);

    // A stalled result beat stays put
    `JKCA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_read_value), "stalled result beat changed")

    // Reset starts the clearing pass, so no beat is taken right after it
    `JKCA_ASSERT_NEXT_ALWAYS(a_clear_after_reset, i_clk, !i_rst_n, o_in_stall, "input taken during clearing pass")

    // One item at a time: an accepted beat makes the block busy
    `JKCA_ASSERT_NEXT_ALWAYS(a_busy_after_accept, i_clk, i_in_valid && !o_in_stall, o_in_stall, "second beat taken while busy")

    // A result only appears while an item is being worked on
    `JKCA_ASSERT_NOW_ALWAYS(a_result_from_item, i_clk, $rose(o_out_valid), $past(o_in_stall), "result without an item in work")

endmodule

bind jackknife_count_accumulator_top jkca_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_read_value (o_read_value)
);

@@ bench/jackknife_count_accumulator_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jackknife count accumulator testbench
// Drives accumulate and read beats through the block under several register
// settings. A mirror of the count table predicts every read, and each read
// result is compared with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module jackknife_count_accumulator_top_tb;
    import jkca_pkg::*;

    // Write to the one index that names no register: it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    localparam int RANDOM_PHASES    = 12;
    localparam int BEATS_PER_PHASE  = 110;
    // Longest accumulate walks all 16 regions; allow for that twice.
    localparam int SETTLE_CYCLES    = 40;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int REPORT_LINES     = 100;
    localparam longint RUN_LIMIT_NS = 1_000_000;

    typedef struct packed {
        logic        op;
        logic [31:0] count;
        logic [2:0]  rand_points;
        logic [2:0]  matcher_index;
        logic [2:0]  excl_count;
        logic [3:0]  excl_region_0;
        logic [3:0]  excl_region_1;
        logic [3:0]  excl_region_2;
        logic [3:0]  excl_region_3;
        logic [3:0]  read_region;
    } t_beat;

    // ------------------------------------------------------------------------
    // Mirror of the count table; holds the reads still owed by the block.
    // ------------------------------------------------------------------------
    class counter_mirror;
        logic [CNT_W-1:0] region_tbl [TBL_DEPTH];
        logic [CNT_W-1:0] random_row [MATCHERS];
        logic [4:0]       num_regions_reg;
        logic [2:0]       tuple_size_reg;
        logic             efficient_reg;
        logic [CNT_W-1:0] pending_reads [$];
        int               errors;
        int               reads_checked;

        function new();
            foreach (region_tbl[k]) region_tbl[k] = '0;
            foreach (random_row[k]) random_row[k] = '0;
            num_regions_reg = 5'd1;
            tuple_size_reg  = 3'd2;
            efficient_reg   = 1'b1;
            errors          = 0;
            reads_checked   = 0;
        endfunction

        function int active_regions();
            if (num_regions_reg == 0) return 1;
            if (num_regions_reg > MAX_REGIONS) return MAX_REGIONS;
            return int'(num_regions_reg);
        endfunction

        function int active_tuple();
            if (tuple_size_reg == 0) return 1;
            if (tuple_size_reg > MAX_TUPLE) return MAX_TUPLE;
            return int'(tuple_size_reg);
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_NUM_REGIONS:    num_regions_reg = data[4:0];
                CFG_TUPLE_SIZE:     tuple_size_reg  = data[2:0];
                CFG_EFFICIENT_MODE: efficient_reg   = data[0];
                default: ;
            endcase
        endfunction

        function logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [31:0] b);
            logic [CNT_W:0] sum;
            sum = {1'b0, a} + {{(CNT_W - 31){1'b0}}, b};
            return sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
        endfunction

        function int slot(int region, int nrand, int matcher);
            return (region * MAX_TUPLE + nrand) * MATCHERS + matcher;
        endfunction

        function int pending();
            return pending_reads.size();
        endfunction

        // Advance the mirror by one accepted beat; queue the value a read owes.
        function void note_beat(t_beat b);
            int               regions;
            int               tsize;
            int               nrand;
            int               mat;
            int               nexcl;
            int               rr;
            int               k;
            logic [3:0]       excl [4];
            logic [CNT_W-1:0] v;
            bit               skip;
            regions  = active_regions();
            tsize    = active_tuple();
            nrand    = int'(b.rand_points);
            mat      = int'(b.matcher_index);
            rr       = int'(b.read_region);
            nexcl    = (b.excl_count > 4) ? 4 : int'(b.excl_count);
            excl[0]  = b.excl_region_0;
            excl[1]  = b.excl_region_1;
            excl[2]  = b.excl_region_2;
            excl[3]  = b.excl_region_3;

            if (b.op == OP_READ) begin
                v = '0;
                if (mat < MATCHERS) begin
                    if (nrand == tsize)
                        v = random_row[mat];
                    else if (nrand < tsize && rr < regions)
                        v = region_tbl[slot(rr, nrand, mat)];
                end
                pending_reads.push_back(v);
                return;
            end

            if (mat >= MATCHERS || nrand > tsize) return;

            if (nrand == tsize) begin
                random_row[mat] = sat_add(random_row[mat], b.count);
            end else if (regions == 1) begin
                k = slot(0, nrand, mat);
                region_tbl[k] = sat_add(region_tbl[k], b.count);
            end else if (efficient_reg) begin
                for (int r = 0; r < regions; r++) begin
                    skip = 1'b0;
                    for (int j = 0; j < nexcl; j++)
                        if (int'(excl[j]) == r) skip = 1'b1;
                    if (!skip) begin
                        k = slot(r, nrand, mat);
                        region_tbl[k] = sat_add(region_tbl[k], b.count);
                    end
                end
            end else if (nexcl > 0 && int'(excl[0]) < regions) begin
                k = slot(int'(excl[0]), nrand, mat);
                region_tbl[k] = sat_add(region_tbl[k], b.count);
            end
        endfunction

        task report(string msg);
            if (errors < REPORT_LINES) $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_read(logic [CNT_W-1:0] got);
            logic [CNT_W-1:0] want;
            if (pending_reads.size() == 0) begin
                report($sformatf("read_value %0h with no read outstanding", got));
                return;
            end
            want = pending_reads.pop_front();
            reads_checked++;
            if (got !== want)
                report($sformatf("read_value %0h, expected %0h", got, want));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Block ports
    // ------------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_op;
    logic [31:0]           i_count;
    logic [2:0]            i_rand_points;
    logic [2:0]            i_matcher_index;
    logic [2:0]            i_excl_count;
    logic [3:0]            i_excl_region_0;
    logic [3:0]            i_excl_region_1;
    logic [3:0]            i_excl_region_2;
    logic [3:0]            i_excl_region_3;
    logic [3:0]            i_read_region;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [CNT_W-1:0]      o_read_value;

    jackknife_count_accumulator_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_count         (i_count),
        .i_rand_points   (i_rand_points),
        .i_matcher_index (i_matcher_index),
        .i_excl_count    (i_excl_count),
        .i_excl_region_0 (i_excl_region_0),
        .i_excl_region_1 (i_excl_region_1),
        .i_excl_region_2 (i_excl_region_2),
        .i_excl_region_3 (i_excl_region_3),
        .i_read_region   (i_read_region),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_read_value    (o_read_value)
    );

    always #1 i_clk = ~i_clk;

    counter_mirror mirror;

    int burst_left      = 0;
    bit sender_gaps_on  = 1'b1;
    bit hold_req        = 1'b0;
    int accum_beats     = 0;
    int read_beats      = 0;
    int settings_used   = 1;
    int in_held_cycles  = 0;
    int long_holds      = 0;

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------

    // Offer one beat and hold it until the block takes it. Open a new burst
    // with a random gap when the current one is spent; keep valid high
    // across beats of a burst.
    task automatic send_beat(input t_beat b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = (!sender_gaps_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_op            <= b.op;
        i_count         <= b.count;
        i_rand_points   <= b.rand_points;
        i_matcher_index <= b.matcher_index;
        i_excl_count    <= b.excl_count;
        i_excl_region_0 <= b.excl_region_0;
        i_excl_region_1 <= b.excl_region_1;
        i_excl_region_2 <= b.excl_region_2;
        i_excl_region_3 <= b.excl_region_3;
        i_read_region   <= b.read_region;
        i_in_valid      <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        mirror.note_beat(b);
        if (b.op == OP_READ) read_beats++;
        else accum_beats++;
    endtask

    // Drop valid, wait for every owed read, then let a trailing walk finish.
    task automatic drain_block();
        i_in_valid <= 1'b0;
        while (mirror.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        mirror.note_config(idx, data);
    endtask

    // Write all three registers; fill the unused data bits with noise.
    task automatic set_config(input logic [4:0] nr, input logic [2:0] ts, input logic em,
                              input bit poke_spare);
        cfg_write(CFG_NUM_REGIONS, nr);
        cfg_write(CFG_TUPLE_SIZE, {2'($urandom), ts});
        cfg_write(CFG_EFFICIENT_MODE, {4'($urandom), em});
        if (poke_spare) cfg_write(CFG_SPARE_IDX, 5'($urandom));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // Beat builders
    // ------------------------------------------------------------------------
    function automatic t_beat make_beat(logic op, logic [31:0] count, logic [2:0] nr,
                                        logic [2:0] mat, logic [2:0] nexcl,
                                        logic [3:0] e0, logic [3:0] e1, logic [3:0] e2,
                                        logic [3:0] e3, logic [3:0] rr);
        t_beat b;
        b.op            = op;
        b.count         = count;
        b.rand_points   = nr;
        b.matcher_index = mat;
        b.excl_count    = nexcl;
        b.excl_region_0 = e0;
        b.excl_region_1 = e1;
        b.excl_region_2 = e2;
        b.excl_region_3 = e3;
        b.read_region   = rr;
        return b;
    endfunction

    function automatic t_beat any_beat();
        t_beat b;
        b.op            = 1'($urandom);
        b.count         = $urandom;
        b.rand_points   = 3'($urandom);
        b.matcher_index = 3'($urandom);
        b.excl_count    = 3'($urandom);
        b.excl_region_0 = 4'($urandom);
        b.excl_region_1 = 4'($urandom);
        b.excl_region_2 = 4'($urandom);
        b.excl_region_3 = 4'($urandom);
        b.read_region   = 4'($urandom);
        return b;
    endfunction

    function automatic logic [31:0] pick_count();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $urandom_range(0, 255);
            2:       return 32'hFFFF_FFFF;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // Region id, mostly among those in use.
    function automatic logic [3:0] pick_region(int regions);
        if ($urandom_range(0, 5) == 0) return 4'($urandom);
        return 4'($urandom_range(0, regions - 1));
    endfunction

    // One group of beats. A shaped group fixes matcher and random-point
    // count, mixes accumulates with reads of the same row, and keeps the
    // other fields mostly in range; a noise group is random throughout.
    task automatic send_group(input bit noise, output int n);
        t_beat b;
        int    regions;
        int    tsize;
        logic [2:0] mat;
        logic [2:0] nr;
        regions = mirror.active_regions();
        tsize   = mirror.active_tuple();
        n       = $urandom_range(3, 8);
        mat     = 3'($urandom);
        nr      = ($urandom_range(0, 6) == 0) ? 3'($urandom) : 3'($urandom_range(0, tsize));
        for (int k = 0; k < n; k++) begin
            b = any_beat();
            if (!noise) begin
                b.matcher_index = mat;
                b.rand_points   = nr;
                b.count         = pick_count();
                b.op            = ($urandom_range(0, 9) < 6) ? OP_ACCUMULATE : OP_READ;
                b.excl_count    = ($urandom_range(0, 4) == 0) ? 3'($urandom)
                                                              : 3'($urandom_range(0, 4));
                b.excl_region_0 = pick_region(regions);
                b.excl_region_1 = pick_region(regions);
                b.excl_region_2 = pick_region(regions);
                b.excl_region_3 = pick_region(regions);
                b.read_region   = pick_region(regions);
            end
            send_beat(b);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int          sent;
        int          n;
        logic [4:0]  nr;
        logic [2:0]  ts;
        logic        em;

        mirror = new();
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_NUM_REGIONS;
        i_cfg_data      <= '0;
        i_in_valid      <= 1'b0;
        i_op            <= OP_ACCUMULATE;
        i_count         <= '0;
        i_rand_points   <= '0;
        i_matcher_index <= '0;
        i_excl_count    <= '0;
        i_excl_region_0 <= '0;
        i_excl_region_1 <= '0;
        i_excl_region_2 <= '0;
        i_excl_region_3 <= '0;
        i_read_region   <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: one region, tuples of two, efficient mode. The
        // first beat simply waits out the clearing sweep.
        // Single region: the count lands in region 0 whatever the exclusions.
        send_beat(make_beat(OP_ACCUMULATE, 32'hFFFF_FFFF, 3'd0, 3'd0, 3'd4,
                            4'd0, 4'd0, 4'd0, 4'd0, 4'd0));
        send_beat(make_beat(OP_ACCUMULATE, 32'hFFFF_FFFF, 3'd0, 3'd0, 3'd0,
                            4'd15, 4'd15, 4'd15, 4'd15, 4'd15));
        send_beat(make_beat(OP_ACCUMULATE, 32'd0, 3'd1, 3'd7, 3'd7,
                            4'd15, 4'd15, 4'd15, 4'd15, 4'd0));
        // All-random row, then random-point counts above the tuple size.
        send_beat(make_beat(OP_ACCUMULATE, 32'h1234_5678, 3'd2, 3'd3, 3'd0,
                            4'd0, 4'd0, 4'd0, 4'd0, 4'd0));
        send_beat(make_beat(OP_ACCUMULATE, 32'd5, 3'd7, 3'd3, 3'd0,
                            4'd0, 4'd0, 4'd0, 4'd0, 4'd0));
        send_beat(make_beat(OP_ACCUMULATE, 32'd9, 3'd3, 3'd1, 3'd0,
                            4'd0, 4'd0, 4'd0, 4'd0, 4'd0));
        send_beat(make_beat(OP_READ, 32'd0, 3'd0, 3'd0, 3'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0));
        // Read region beyond those in use returns zero.
        send_beat(make_beat(OP_READ, 32'd0, 3'd0, 3'd0, 3'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd1));
        // Read region is ignored on the all-random row.
        send_beat(make_beat(OP_READ, 32'd0, 3'd2, 3'd3, 3'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd15));
        send_beat(make_beat(OP_READ, 32'd0, 3'd7, 3'd3, 3'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0));
        send_beat(make_beat(OP_READ, 32'd0, 3'd1, 3'd7, 3'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0));
        drain_block();

        // Naive mode over five regions, tuple size clamped from seven to four.
        set_config(5'd5, 3'd7, 1'b0, 1'b1);
        // No exclusions: nothing changes.
        send_beat(make_beat(OP_ACCUMULATE, 32'd11, 3'd0, 3'd2, 3'd0,
                            4'd1, 4'd0, 4'd0, 4'd0, 4'd0));
        // Target region beyond those in use: nothing changes.
        send_beat(make_beat(OP_ACCUMULATE, 32'd13, 3'd0, 3'd2, 3'd1,
                            4'd9, 4'd0, 4'd0, 4'd0, 4'd0));
        // Exclusion count above four clamps; only the first id matters here.
        send_beat(make_beat(OP_ACCUMULATE, 32'd77, 3'd0, 3'd2, 3'd7,
                            4'd4, 4'd1, 4'd2, 4'd3, 4'd0));
        send_beat(make_beat(OP_READ, 32'd0, 3'd0, 3'd2, 3'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd4));
        send_beat(make_beat(OP_READ, 32'd0, 3'd0, 3'd2, 3'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd9));
        send_beat(make_beat(OP_READ, 32'd0, 3'd4, 3'd2, 3'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0));
        drain_block();

        // Region count clamped from 31 to 16, tuple size raised from 0 to 1.
        set_config(5'd31, 3'd0, 1'b1, 1'b0);
        send_beat(make_beat(OP_ACCUMULATE, 32'hFFFF_FFFF, 3'd0, 3'd5, 3'd7,
                            4'd0, 4'd5, 4'd15, 4'd5, 4'd0));
        send_beat(make_beat(OP_ACCUMULATE, 32'hA5A5_A5A5, 3'd1, 3'd5, 3'd0,
                            4'd0, 4'd0, 4'd0, 4'd0, 4'd0));
        send_beat(make_beat(OP_ACCUMULATE, 32'd1, 3'd0, 3'd4, 3'd2,
                            4'd3, 4'd3, 4'd0, 4'd0, 4'd0));
        send_beat(make_beat(OP_READ, 32'd0, 3'd0, 3'd5, 3'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0));
        send_beat(make_beat(OP_READ, 32'd0, 3'd0, 3'd5, 3'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd6));
        send_beat(make_beat(OP_READ, 32'd0, 3'd0, 3'd5, 3'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd15));
        send_beat(make_beat(OP_READ, 32'd0, 3'd1, 3'd5, 3'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd15));
        send_beat(make_beat(OP_READ, 32'd0, 3'd0, 3'd4, 3'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd3));
        drain_block();

        // Random part: fixed extremes first, then random settings.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       begin nr = 5'd16; ts = 3'd4; em = 1'b1; end
                1:       begin nr = 5'd16; ts = 3'd4; em = 1'b0; end
                2:       begin nr = 5'd31; ts = 3'd7; em = 1'b1; end
                3:       begin nr = 5'd0;  ts = 3'd0; em = 1'b0; end
                4:       begin nr = 5'd1;  ts = 3'd1; em = 1'b1; end
                5:       begin nr = 5'd2;  ts = 3'd3; em = 1'b0; end
                6:       begin nr = 5'd17; ts = 3'd5; em = 1'b1; end
                default: begin nr = 5'($urandom); ts = 3'($urandom); em = 1'($urandom); end
            endcase
            set_config(nr, ts, em, phase == 0);
            // Hold the receiver off early in one busy phase so that the
            // output register fills and the block stalls its input.
            if (phase == 1) hold_req = 1'b1;
            sender_gaps_on = (phase % 3 != 2);
            sent = 0;
            while (sent < BEATS_PER_PHASE) begin
                send_group($urandom_range(0, 4) == 0, n);
                sent += n;
            end
            drain_block();
        end

        $display("Sent %0d accumulate and %0d read beats over %0d register settings.",
                 accum_beats, read_beats, settings_used);
        $display("Compared %0d reads; input held back on %0d cycles, %0d long output hold-off.",
                 mirror.reads_checked, in_held_cycles, long_holds);
        if (mirror.errors == 0 && mirror.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: stall in segments of random duty; on request, hold off for a
    // long stretch counted here.
    // ------------------------------------------------------------------------
    initial begin : out_stall_gen
        int seg_left;
        int duty;
        seg_left = 0;
        duty     = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                long_holds++;
                i_out_stall <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(20, 120);
                    case ($urandom_range(0, 3))
                        0:       duty = 0;
                        1:       duty = 25;
                        2:       duty = 50;
                        default: duty = 80;
                    endcase
                end
                seg_left--;
                i_out_stall <= ($urandom_range(0, 99) < duty);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output monitor: check every accepted read beat.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) mirror.check_read(o_read_value);
        if (i_rst_n && i_in_valid && o_in_stall) in_held_cycles++;
    end

    // Guard against a hung handshake.
    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
